FILE: rtl/pse_pkg.sv
// Shared constants and types of the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 3;
  localparam int ST_W            = 3;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_END  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW      = 3'd1;
  localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [ST_W-1:0] ST_DEPTH    = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } alu_rsp_t;

endpackage

FILE: rtl/pse_alu.sv
// Shared arithmetic unit: add, subtract, multiply, radix-2 signed divide.
`timescale 1ns / 1ps
module pse_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pse_pkg::alu_req_t           req_i,
  input  logic [pse_pkg::DATA_W-1:0]  a_i,
  input  logic [pse_pkg::DATA_W-1:0]  b_i,
  output pse_pkg::alu_rsp_t           rsp_o
);
  import pse_pkg::*;

  localparam int SW = $clog2(DATA_W);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_e;

  alu_state_e        state_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;
  logic [SW-1:0]     step_q;
  logic              neg_q;
  logic [DATA_W-1:0] res_q;
  logic              done_q;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              take;

  assign mag_a   = a_i[DATA_W-1] ? (~a_i + DATA_W'(1)) : a_i;
  assign mag_b   = b_i[DATA_W-1] ? (~b_i + DATA_W'(1)) : b_i;
  assign prod    = a_i * b_i;
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = ~diff[DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            unique case (req_i.op)
              ALU_ADD: begin
                res_q  <= a_i + b_i;
                done_q <= 1'b1;
              end
              ALU_SUB: begin
                res_q  <= a_i - b_i;
                done_q <= 1'b1;
              end
              ALU_MUL: begin
                res_q  <= prod;
                done_q <= 1'b1;
              end
              ALU_DIV: begin
                rem_q   <= '0;
                quo_q   <= mag_a;
                dvs_q   <= mag_b;
                neg_q   <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
                step_q  <= '0;
                state_q <= A_DIV;
              end
              default: ;
            endcase
          end
        end
        A_DIV: begin
          rem_q  <= take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
          quo_q  <= {quo_q[DATA_W-2:0], take};
          step_q <= step_q + SW'(1);
          if (step_q == SW'(DATA_W - 1)) begin
            state_q <= A_FIX;
          end
        end
        A_FIX: begin
          res_q   <= neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: rtl/postfix_stack_evaluator_unit.sv
// Top level of the postfix stack evaluator: token sequencer, value stack and result stage.
`timescale 1ns / 1ps
// Evaluates a reverse Polish integer expression one token at a time and returns one
// result per token. The stack top sits in a register and the lower entries in a
// STACK_DEPTH-entry memory, so no clearing pass is needed after reset. A push, an end
// mark, an ignored token or a token that raises an error goes from idle straight to the
// emit state; add, subtract and multiply first take one memory read for the left operand
// and one pass through the shared arithmetic unit; divide runs the one-bit-per-cycle
// divider inside that unit. The next token is accepted while a finished result still
// waits in the output register.
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pse_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [pse_pkg::DATA_W-1:0] number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pse_pkg::ST_W-1:0]          status_o,
  output logic signed [pse_pkg::DATA_W-1:0] value_o,
  output logic                              finished_o
);
  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      cnt_q;
  logic [ST_W-1:0]    err_q;
  logic [DATA_W-1:0]  top_q;
  logic [OP_W-1:0]    op_q;
  logic               fin_q;
  logic [ST_W-1:0]    end_st_q;
  logic [DATA_W-1:0]  end_val_q;
  logic               out_valid_q;
  logic [ST_W-1:0]    out_status_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic               out_finished_q;

  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [DATA_W-1:0]  rd_q;

  logic               accept;
  logic               out_free;
  logic               is_arith;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;
  logic [AW-1:0]      wr_idx;
  logic [AW-1:0]      rd_idx;
  logic               mem_we;
  logic [ST_W-1:0]    emit_st;
  logic [DATA_W-1:0]  emit_val;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_arith   = (opcode_i >= OP_ADD) && (opcode_i <= OP_DIV);
  assign cnt_m1     = cnt_q - CW'(1);
  assign cnt_m2     = cnt_q - CW'(2);
  assign wr_idx     = cnt_m1[AW-1:0];
  assign rd_idx     = cnt_m2[AW-1:0];
  assign mem_we     = accept && (err_q == ST_OK) && (opcode_i == OP_PUSH) &&
                      (cnt_q != '0) && (cnt_q < CW'(STACK_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= top_q;
    end
    rd_q <= mem[rd_idx];
  end

  always_comb begin
    alu_req.start = (state_q == S_EXEC);
    unique case (op_q)
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_ADD;
    endcase
  end

  pse_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (rd_q),
    .b_i   (top_q),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    if (fin_q) begin
      emit_st  = end_st_q;
      emit_val = end_val_q;
    end else begin
      emit_st  = err_q;
      emit_val = ((err_q == ST_OK) && (cnt_q != '0)) ? top_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            fin_q <= 1'b0;
            op_q  <= opcode_i;
            if (opcode_i == OP_END) begin
              fin_q     <= 1'b1;
              end_st_q  <= err_q;
              end_val_q <= '0;
              if (err_q == ST_OK) begin
                if (cnt_q == CW'(1)) begin
                  end_val_q <= top_q;
                end else begin
                  end_st_q <= ST_DEPTH;
                end
              end
              cnt_q   <= '0;
              err_q   <= ST_OK;
              state_q <= S_EMIT;
            end else if ((err_q != ST_OK) || ((opcode_i != OP_PUSH) && !is_arith)) begin
              state_q <= S_EMIT;
            end else if (opcode_i == OP_PUSH) begin
              if (cnt_q >= CW'(STACK_DEPTH)) begin
                err_q <= ST_OVERFLOW;
              end else begin
                top_q <= number_i;
                cnt_q <= cnt_q + CW'(1);
              end
              state_q <= S_EMIT;
            end else if (cnt_q < CW'(2)) begin
              err_q   <= ST_FEW;
              state_q <= S_EMIT;
            end else if ((opcode_i == OP_DIV) && (top_q == '0)) begin
              err_q   <= ST_DIVZERO;
              cnt_q   <= cnt_m2;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: state_q <= S_WAIT;
        S_WAIT: begin
          if (alu_rsp.done) begin
            top_q   <= alu_rsp.res;
            cnt_q   <= cnt_m1;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_status_q   <= emit_st;
            out_value_q    <= emit_val;
            out_finished_q <= fin_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;
  assign finished_o  = out_finished_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_alu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_WAIT))
    else $error("arithmetic result outside wait state");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_END)) |=> ((cnt_q == '0) && (err_q == ST_OK)))
    else $error("end mark did not clear the stack");

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (value_o == '0))
    else $error("error result carries a nonzero value");

endmodule
